### src/pfc_pkg.sv
// Shared types and constants for the particle frame checker.
package pfc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned SUM_W = 16;
    localparam int unsigned NUM_VALUES = 3;
    localparam int unsigned RESULT_BYTES = 7;

    localparam logic [BYTE_W-1:0] HDR_FIRST = 8'h42;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h4d;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_HEADER   = 2'd1,
        ST_BAD_CHECKSUM = 2'd2
    } t_status;

    typedef struct packed {
        logic [VALUE_W-1:0] pm10_value;
        logic [VALUE_W-1:0] pm2_5_value;
        logic [VALUE_W-1:0] pm1_value;
        t_status            status;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);
    localparam int unsigned TDATA_W = RESULT_BYTES * 8;

endpackage

### src/pfc_frame_core.sv
// Frame state tracking, header and checksum check, value capture and result build.
module pfc_frame_core #(
    parameter int unsigned FRAME_LEN = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [pfc_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_start,
    input  logic                        i_can_load,
    output logic                        o_advance,
    output logic                        o_load,
    output pfc_pkg::t_result            o_result
);
    import pfc_pkg::*;

    localparam int unsigned POS_W = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] CK_HIGH = POS_W'(FRAME_LEN - 2);
    localparam logic [POS_W-1:0] PM_BASE = POS_W'(4);

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic               r_hdr_good, n_hdr_good;
    logic [BYTE_W-1:0]  r_ck_high, n_ck_high;
    logic [VALUE_W-1:0] r_pm [NUM_VALUES];
    logic [VALUE_W-1:0] n_pm [NUM_VALUES];

    logic [POS_W-1:0]   pos;
    logic               is_last;
    logic [SUM_W-1:0]   expect_sum;
    t_status            status;

    assign pos        = i_start ? '0 : r_pos;
    assign is_last    = (pos == LAST);
    assign o_advance  = i_valid && (!is_last || i_can_load);
    assign o_load     = o_advance && is_last;
    assign expect_sum = {r_ck_high, i_byte};

    always_comb begin
        n_pos      = is_last ? '0 : pos + POS_W'(1);
        n_hdr_good = r_hdr_good;
        n_sum      = r_sum;
        n_ck_high  = r_ck_high;
        for (int k = 0; k < NUM_VALUES; k++) begin
            n_pm[k] = r_pm[k];
            if (pos == PM_BASE + POS_W'(2 * k)) begin
                n_pm[k][VALUE_W-1:BYTE_W] = i_byte;
            end
            if (pos == PM_BASE + POS_W'(2 * k + 1)) begin
                n_pm[k][BYTE_W-1:0] = i_byte;
            end
        end
        if (pos == '0) begin
            n_hdr_good = (i_byte == HDR_FIRST);
            n_sum      = SUM_W'(i_byte);
        end else begin
            if (pos == POS_W'(1)) begin
                n_hdr_good = r_hdr_good && (i_byte == HDR_SECOND);
            end
            if (pos < CK_HIGH) begin
                n_sum = r_sum + SUM_W'(i_byte);
            end
        end
        if (pos == CK_HIGH) begin
            n_ck_high = i_byte;
        end
    end

    always_comb begin
        if (!r_hdr_good) begin
            status = ST_BAD_HEADER;
        end else if (expect_sum != r_sum) begin
            status = ST_BAD_CHECKSUM;
        end else begin
            status = ST_OK;
        end
        o_result.status      = status;
        o_result.pm1_value   = (status == ST_OK) ? r_pm[0] : '0;
        o_result.pm2_5_value = (status == ST_OK) ? r_pm[1] : '0;
        o_result.pm10_value  = (status == ST_OK) ? r_pm[2] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_hdr_good <= 1'b0;
            r_ck_high  <= '0;
            for (int k = 0; k < NUM_VALUES; k++) begin
                r_pm[k] <= '0;
            end
        end else if (o_advance) begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_hdr_good <= n_hdr_good;
            r_ck_high  <= n_ck_high;
            for (int k = 0; k < NUM_VALUES; k++) begin
                r_pm[k] <= n_pm[k];
            end
        end
    end

endmodule

### src/pfc_out_stage.sv
// Result register with valid flag on the master side.
module pfc_out_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  pfc_pkg::t_result            i_result,
    output logic                        o_can_load,
    output logic                        o_valid,
    input  logic                        i_ready,
    output pfc_pkg::t_result            o_result
);
    import pfc_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### src/particle_frame_checker.sv
// Top level of the particle frame checker: input register, frame core, result register.
// A frame's last byte waits in the input register until the result register can load its result.
// Throughput: one byte per cycle unless stalled; the result register drains while later bytes are taken.
// A waiting result stalls only the next last-of-frame byte, held in the input register.
// Reset: synchronous, active low; clears position, sum, header mark, checksum byte,
// captured values and all valid flags.
module particle_frame_checker #(
    parameter int unsigned FRAME_LEN = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [pfc_pkg::BYTE_W-1:0]    i_s_tdata,   // rx_byte
    input  logic                          i_s_tuser,   // frame_start
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [pfc_pkg::TDATA_W-1:0]   o_m_tdata    // status, pm1, pm2_5, pm10, zero pad
);
    import pfc_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;

    logic    advance;
    logic    load;
    logic    can_load;
    t_result core_result;
    t_result out_result;

    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tdata  = {{(TDATA_W - RESULT_W){1'b0}}, out_result};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
    end

    pfc_frame_core #(
        .FRAME_LEN (FRAME_LEN)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid),
        .i_byte     (r_in_byte),
        .i_start    (r_in_start),
        .i_can_load (can_load),
        .o_advance  (advance),
        .o_load     (load),
        .o_result   (core_result)
    );

    pfc_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_result   (core_result),
        .o_can_load (can_load),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_result   (out_result)
    );

endmodule

### test/particle_frame_checker_test.sv
// Self-checking testbench for the particle frame checker: random byte streams against a frame parser.
`timescale 1ns / 100ps

module particle_frame_checker_test;
    import pfc_pkg::*;

    localparam int unsigned FRAME_LEN = 32;
    localparam int unsigned RANDOM_BYTES = 980;
    localparam int unsigned QUIET_TAIL = 150;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef struct {
        logic [BYTE_W-1:0] rx;
        logic              sof;
    } t_sensor_byte;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [BYTE_W-1:0]    i_s_tdata = '0;   // rx_byte
    logic                 i_s_tuser = 1'b0; // frame_start
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [TDATA_W-1:0]   o_m_tdata;        // status, pm1, pm2_5, pm10, zero pad

    t_sensor_byte         byte_queue[$];
    t_result              expected_frames[$];
    logic [BYTE_W-1:0]    frame_buf[FRAME_LEN];
    bit                   stream_aligned = 1'b1;

    int unsigned          next_pos = 0;
    logic [SUM_W-1:0]     frame_sum = '0;
    bit                   hdr_ok = 1'b0;
    logic [BYTE_W-1:0]    cks_high = '0;
    logic [VALUE_W-1:0]   pm_capture[NUM_VALUES] = '{default: '0};

    int unsigned          bytes_taken = 0;
    int unsigned          send_gap = 0;
    int unsigned          send_odds = 0;
    int unsigned          recv_gap = 0;
    int unsigned          recv_odds = 4;
    int unsigned          results_seen = 0;
    int unsigned          mismatches = 0;

    particle_frame_checker #(
        .FRAME_LEN (FRAME_LEN)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit parse_byte(input logic [BYTE_W-1:0] rx, input logic sof,
                                      output t_result res);
        int unsigned at;
        bit          done;
        at = sof ? 0 : next_pos;
        done = 1'b0;
        res = '0;
        if (at > FRAME_LEN - 1)
            at = 0;
        if (at == 0) begin
            hdr_ok = (rx == HDR_FIRST);
            frame_sum = '0;
        end else if (at == 1) begin
            hdr_ok = hdr_ok && (rx == HDR_SECOND);
        end
        if (at + 2 < FRAME_LEN)
            frame_sum = frame_sum + SUM_W'(rx);
        if (at >= 4 && at <= 9) begin
            if (at % 2 == 0)
                pm_capture[(at - 4) / 2][15:8] = rx;
            else
                pm_capture[(at - 4) / 2][7:0] = rx;
        end
        if (at == FRAME_LEN - 2)
            cks_high = rx;
        if (at == FRAME_LEN - 1) begin
            if (!hdr_ok) begin
                res.status = ST_BAD_HEADER;
            end else if ({cks_high, rx} != frame_sum) begin
                res.status = ST_BAD_CHECKSUM;
            end else begin
                res.status = ST_OK;
                res.pm1_value = pm_capture[0];
                res.pm2_5_value = pm_capture[1];
                res.pm10_value = pm_capture[2];
            end
            next_pos = 0;
            done = 1'b1;
        end else begin
            next_pos = at + 1;
        end
        return done;
    endfunction

    task automatic seal_frame();
        logic [SUM_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < FRAME_LEN - 2; i++)
            sum = sum + SUM_W'(frame_buf[i]);
        {frame_buf[FRAME_LEN-2], frame_buf[FRAME_LEN-1]} = sum;
    endtask

    task automatic build_frame(input logic [VALUE_W-1:0] pm1, input logic [VALUE_W-1:0] pm2_5,
                               input logic [VALUE_W-1:0] pm10);
        logic [SUM_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < FRAME_LEN; i++)
            frame_buf[i] = BYTE_W'($urandom);
        frame_buf[0] = HDR_FIRST;
        frame_buf[1] = HDR_SECOND;
        {frame_buf[4], frame_buf[5]} = pm1;
        {frame_buf[6], frame_buf[7]} = pm2_5;
        {frame_buf[8], frame_buf[9]} = pm10;
        for (int i = 0; i < FRAME_LEN - 2; i++)
            sum = sum + SUM_W'(frame_buf[i]);
        {frame_buf[FRAME_LEN-2], frame_buf[FRAME_LEN-1]} = sum;
    endtask

    task automatic queue_frame(input int unsigned count, input logic sof);
        t_sensor_byte item;
        for (int unsigned i = 0; i < count; i++) begin
            item.rx = frame_buf[i];
            item.sof = (i == 0) ? sof : 1'b0;
            byte_queue.push_back(item);
        end
        stream_aligned = (count == FRAME_LEN);
    endtask

    task automatic queue_noise(input int unsigned count);
        t_sensor_byte item;
        for (int unsigned i = 0; i < count; i++) begin
            item.rx = BYTE_W'($urandom);
            item.sof = ($urandom_range(7) == 0);
            byte_queue.push_back(item);
        end
        stream_aligned = 1'b0;
    endtask

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_sensor_byte item;
        t_result      res;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                bytes_taken++;
                if (parse_byte(i_s_tdata, i_s_tuser, res))
                    expected_frames.push_back(res);
                if (bytes_taken % 64 == 0) begin
                    case ($urandom_range(2))
                        0: send_odds = 0;
                        1: send_odds = 3;
                        default: send_odds = 10;
                    endcase
                end
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (byte_queue.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                end else if (byte_queue.size() > QUIET_TAIL && send_odds != 0
                             && $urandom_range(send_odds) == 0) begin
                    send_gap = $urandom_range(15);
                    i_s_tvalid <= 1'b0;
                end else begin
                    item = byte_queue.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= item.rx;
                    i_s_tuser <= item.sof;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (results_seen % 8 == 0)
                    recv_odds = $urandom_range(3) * 3;
                if (expected_frames.size() == 0) begin
                    note_error($sformatf("result with none expected: %h", o_m_tdata));
                end else begin
                    want = expected_frames.pop_front();
                    got = t_result'(o_m_tdata[RESULT_W-1:0]);
                    if (got.status !== want.status)
                        note_error($sformatf("status expected %s got %0d",
                                             want.status.name(), got.status));
                    if (got.pm1_value !== want.pm1_value)
                        note_error($sformatf("pm1 expected %h got %h",
                                             want.pm1_value, got.pm1_value));
                    if (got.pm2_5_value !== want.pm2_5_value)
                        note_error($sformatf("pm2_5 expected %h got %h",
                                             want.pm2_5_value, got.pm2_5_value));
                    if (got.pm10_value !== want.pm10_value)
                        note_error($sformatf("pm10 expected %h got %h",
                                             want.pm10_value, got.pm10_value));
                    if (o_m_tdata[TDATA_W-1:RESULT_W] !== '0)
                        note_error($sformatf("pad expected 0 got %h",
                                             o_m_tdata[TDATA_W-1:RESULT_W]));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_m_tready <= 1'b0;
            end else if (byte_queue.size() > QUIET_TAIL && recv_odds != 0
                         && $urandom_range(recv_odds) == 0) begin
                recv_gap = $urandom_range(15);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned total;
        int unsigned kind;

        build_frame(16'hffff, 16'h0000, 16'h8001);
        frame_buf[10] = 8'h00;
        frame_buf[11] = 8'hff;
        frame_buf[FRAME_LEN-3] = 8'h00;
        seal_frame();
        queue_frame(FRAME_LEN, 1'b1);
        build_frame(BYTE_W'($urandom) << 8, 16'h00ff, 16'h7ffe);
        queue_frame(FRAME_LEN, 1'b0);
        build_frame(16'h1234, 16'h5678, 16'h9abc);
        frame_buf[0] = 8'h43;
        queue_frame(FRAME_LEN, 1'b1);
        build_frame(16'h0001, 16'h0002, 16'h0003);
        frame_buf[1] = 8'h4c;
        queue_frame(FRAME_LEN, 1'b0);
        build_frame(16'haaaa, 16'h5555, 16'hffff);
        frame_buf[FRAME_LEN-1] = frame_buf[FRAME_LEN-1] ^ 8'h01;
        queue_frame(FRAME_LEN, 1'b1);
        build_frame(16'h4242, 16'h4d4d, 16'h0000);
        frame_buf[0] = 8'h00;
        frame_buf[FRAME_LEN-2] = frame_buf[FRAME_LEN-2] ^ 8'h80;
        queue_frame(FRAME_LEN, 1'b1);
        build_frame(16'hdead, 16'hbeef, 16'hcafe);
        queue_frame(12, 1'b1);
        build_frame(16'h0f0f, 16'hf0f0, 16'h00ff);
        queue_frame(FRAME_LEN, 1'b1);
        build_frame(16'hffff, 16'hffff, 16'hffff);
        for (int i = 2; i < FRAME_LEN - 2; i++)
            if (i < 4 || i > 9)
                frame_buf[i] = 8'hff;
        seal_frame();
        queue_frame(FRAME_LEN, 1'b1);

        total = byte_queue.size() + RANDOM_BYTES;
        while (byte_queue.size() < total) begin
            kind = $urandom_range(9);
            build_frame(VALUE_W'($urandom), VALUE_W'($urandom), VALUE_W'($urandom));
            case (kind)
                6: frame_buf[$urandom_range(FRAME_LEN-1)] ^= BYTE_W'($urandom_range(1, 255));
                7: frame_buf[$urandom_range(1)] = BYTE_W'($urandom);
                default: ;
            endcase
            if (kind == 8)
                queue_frame($urandom_range(1, FRAME_LEN - 1), 1'b1);
            else if (kind == 9)
                queue_noise($urandom_range(1, 40));
            else
                queue_frame(FRAME_LEN, stream_aligned ? 1'($urandom) : 1'b1);
        end
        total = byte_queue.size();

        while (bytes_taken < total)
            @(posedge i_clk);
        while (expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
src/pfc_pkg.sv
src/pfc_frame_core.sv
src/pfc_out_stage.sv
src/particle_frame_checker.sv
test/particle_frame_checker_test.sv
